FILE: rtl/cgpg_pkg.sv
// Package for the grid point generator: field widths, register codes,
// fixed-point constants and the arctangent table of the CORDIC unit.
// Depends on nothing; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package cgpg_pkg;

  // Field and register widths
  localparam int STEP_W = 6;
  localparam int SPC_W  = 13;
  localparam int IDX_W  = 7;
  localparam int POS_W  = 20;
  localparam int RAD_W  = 20;
  localparam int BRG_W  = 17;
  localparam int CFG_W  = 13;
  localparam int CFG_A  = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_A-1:0] REG_STEPS_X      = 2'd0;
  localparam logic [CFG_A-1:0] REG_STEPS_Y      = 2'd1;
  localparam logic [CFG_A-1:0] REG_SPACING      = 2'd2;
  localparam logic [CFG_A-1:0] REG_INCLUDE_ZERO = 2'd3;

  // Reset values of the registers
  localparam logic [STEP_W-1:0] STEPS_RST   = 6'd1;
  localparam logic [SPC_W-1:0]  SPACING_RST = 13'd256;

  // Step count ceiling
  localparam int MAX_STEPS = 63;
  localparam logic [7:0] MAX_STEPS_V = 8'(MAX_STEPS);

  // Fixed-point formats
  localparam int FRAC_BITS  = 8;
  localparam int GUARD_BITS = 8;
  localparam int ANG_FRAC   = 20;
  localparam int CORDIC_ITERS_DEF = 16;

  // CORDIC datapath
  localparam int DP_W      = 32;
  localparam int HALF_TURN = 180;
  localparam int HALF_Z    = HALF_TURN * (2 ** ANG_FRAC);
  localparam int BRG_LIM   = HALF_TURN * (2 ** FRAC_BITS);
  localparam int BRG_SHIFT = ANG_FRAC - FRAC_BITS;
  localparam logic [29:0] INV_GAIN = 30'd652032874;

  // atan(2^-i) in degrees, 20 fraction bits
  function automatic logic [25:0] atan_lut(input logic [4:0] i);
    logic [25:0] a;
    unique case (i)
      5'd0:    a = 26'd47185920;
      5'd1:    a = 26'd27855475;
      5'd2:    a = 26'd14718068;
      5'd3:    a = 26'd7471121;
      5'd4:    a = 26'd3750058;
      5'd5:    a = 26'd1876857;
      5'd6:    a = 26'd938658;
      5'd7:    a = 26'd469357;
      5'd8:    a = 26'd234682;
      5'd9:    a = 26'd117342;
      5'd10:   a = 26'd58671;
      5'd11:   a = 26'd29335;
      5'd12:   a = 26'd14668;
      5'd13:   a = 26'd7334;
      5'd14:   a = 26'd3667;
      5'd15:   a = 26'd1833;
      5'd16:   a = 26'd917;
      5'd17:   a = 26'd458;
      5'd18:   a = 26'd229;
      5'd19:   a = 26'd115;
      5'd20:   a = 26'd57;
      5'd21:   a = 26'd29;
      5'd22:   a = 26'd14;
      5'd23:   a = 26'd7;
      default: a = 26'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cgpg_if.sv
// Valid/ready channel interfaces: point requests in, grid points out.
// Depends on cgpg_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cgpg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cgpg_pt_if import cgpg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic        [RAD_W-1:0] radius;
  logic signed [BRG_W-1:0] bearing;
  logic                    last_point;

  modport source (output valid, output x_pos, output y_pos, output radius,
                  output bearing, output last_point, input ready);
  modport sink   (input valid, input x_pos, input y_pos, input radius,
                  input bearing, input last_point, output ready);
endinterface

`default_nettype wire

FILE: rtl/cartesian_grid_point_generator_core.sv
// Grid point generator: walks a raster of points and gives each point's
// position, radius and compass bearing. Needs cgpg_pkg, cgpg_if, cgpg_cordic.
// Use: each transaction on req asks for the next grid point; restart=1 goes
// back to the first point. Columns step in the outer loop, rows in the inner
// one, over -steps..+steps on each axis; the origin is dropped unless
// include_zero is set. Each point leaves on pt as one transaction, with
// last_point marking the end of the grid. An empty grid (no steps, origin
// dropped) takes the request and gives nothing.
// Timing: req is taken only while no point is in work. After its request a
// point passes through the position multiply, the CORDIC unit's set-up,
// CORDIC_ITERS rotations, gain multiply, rounding and the output register
// load. The rotation loop of the shared CORDIC stage sets the rate: a new
// request is taken only once the previous point is in the output register
// and the core is back in idle. The pt output register holds a finished
// point while the receiver stalls; the next request is still taken and its
// point waits until the register frees. Reset (rst, synchronous) restores
// the register defaults and makes the next request start from the first
// point. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while idle, the core does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_grid_point_generator_core import cgpg_pkg::*; #(
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_A-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  cgpg_req_if.sink         req,
  cgpg_pt_if.source        pt
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]              state;
  logic [STEP_W-1:0]       steps_x, steps_y;
  logic [SPC_W-1:0]        spacing;
  logic                    include_zero;
  logic signed [IDX_W-1:0] col_index, row_index;
  logic                    scan_started;
  logic signed [IDX_W-1:0] pt_col, pt_row;
  logic                    pt_last;
  logic signed [POS_W-1:0] x_hold, y_hold;

  logic [STEP_W-1:0]       sx_u, sy_u;
  logic signed [IDX_W-1:0] sx, sy, nsx, nsy, c0, r0, c1, r1, c2, r2;
  logic                    out_range, reload, skip, last, grid_empty, acc;
  logic signed [POS_W-1:0] x_prod, y_prod;
  logic                    cordic_start, cordic_busy, load_out;
  logic [RAD_W-1:0]        cordic_radius;
  logic signed [BRG_W-1:0] cordic_bearing;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_x      <= STEPS_RST;
      steps_y      <= STEPS_RST;
      spacing      <= SPACING_RST;
      include_zero <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEPS_X:      steps_x      <= cfg_data[STEP_W-1:0];
        REG_STEPS_Y:      steps_y      <= cfg_data[STEP_W-1:0];
        REG_SPACING:      spacing      <= cfg_data[SPC_W-1:0];
        REG_INCLUDE_ZERO: include_zero <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // index walk for the request at hand
  always_comb begin
    sx_u = (8'(steps_x) > MAX_STEPS_V) ? MAX_STEPS_V[STEP_W-1:0] : steps_x;
    sy_u = (8'(steps_y) > MAX_STEPS_V) ? MAX_STEPS_V[STEP_W-1:0] : steps_y;
    sx   = $signed({1'b0, sx_u});
    sy   = $signed({1'b0, sy_u});
    nsx  = -sx;
    nsy  = -sy;
    grid_empty = (sx_u == '0) && (sy_u == '0) && !include_zero;
    out_range  = (col_index < nsx) || (col_index > sx) ||
                 (row_index < nsy) || (row_index > sy);
    reload = req.restart || !scan_started || out_range;
    c0 = reload ? nsx : col_index;
    r0 = reload ? nsy : row_index;
    // drop the origin by index
    skip = (c0 == '0) && (r0 == '0) && !include_zero;
    c1 = c0;
    r1 = r0;
    if (skip) begin
      if (r0 == sy) begin
        r1 = nsy;
        c1 = c0 + 7'sd1;
      end else begin
        r1 = r0 + 7'sd1;
      end
    end
    last = (c1 == sx) && (r1 == sy);
    // wrap on equality: the row never passes sy
    c2 = c1;
    if (r1 == sy) begin
      r2 = nsy;
      c2 = c1 + 7'sd1;
    end else begin
      r2 = r1 + 7'sd1;
    end
  end

  assign req.ready    = (state == ST_IDLE);
  assign acc          = req.valid && req.ready;
  assign x_prod       = pt_col * $signed({1'b0, spacing});
  assign y_prod       = pt_row * $signed({1'b0, spacing});
  assign cordic_start = (state == ST_MUL);
  assign load_out     = (state == ST_WAIT) && !cordic_busy && (!pt.valid || pt.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      col_index    <= '0;
      row_index    <= '0;
      scan_started <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            if (grid_empty) begin
              scan_started <= 1'b0;
            end else begin
              pt_col       <= c1;
              pt_row       <= r1;
              pt_last      <= last;
              scan_started <= !last;
              col_index    <= last ? c1 : c2;
              row_index    <= last ? r1 : r2;
              state        <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          x_hold <= x_prod;
          y_hold <= y_prod;
          state  <= ST_WAIT;
        end
        ST_WAIT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register: hold the point until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      pt.valid <= 1'b0;
    end else if (load_out) begin
      pt.valid <= 1'b1;
    end else if (pt.ready) begin
      pt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pt.x_pos      <= x_hold;
      pt.y_pos      <= y_hold;
      pt.radius     <= cordic_radius;
      pt.bearing    <= cordic_bearing;
      pt.last_point <= pt_last;
    end
  end

  cgpg_cordic #(
    .ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .x       (x_prod),
    .y       (y_prod),
    .busy    (cordic_busy),
    .radius  (cordic_radius),
    .bearing (cordic_bearing)
  );

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (acc && !grid_empty) |=> (state == ST_MUL))
    else $error("request taken but no point started");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!pt.valid || pt.ready))
    else $error("pending point overwritten");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    $fell(scan_started) |-> $past(acc && (grid_empty || last)))
    else $error("walk ended without a last point or empty grid");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cordic_start |=> (cordic_busy && state == ST_WAIT))
    else $error("cordic did not take the point");

endmodule

`default_nettype wire

FILE: rtl/cgpg_cordic.sv
// Iterative CORDIC vectoring unit: radius and compass bearing of one point,
// one rotation per cycle through a single shift/add stage.
// Depends on cgpg_pkg for formats, gain constant and arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module cgpg_cordic import cgpg_pkg::*; #(
  parameter int ITERS = CORDIC_ITERS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [POS_W-1:0] x,
  input  logic signed [POS_W-1:0] y,
  output logic                    busy,
  output logic        [RAD_W-1:0] radius,
  output logic signed [BRG_W-1:0] bearing
);

  localparam int ITER_W = $clog2(ITERS);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITERS - 1);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_INIT  = 3'd1;
  localparam logic [2:0] C_ITER  = 3'd2;
  localparam logic [2:0] C_GAIN  = 3'd3;
  localparam logic [2:0] C_ROUND = 3'd4;

  localparam logic [61:0] RAD_RND = 62'(1) << 37;
  localparam logic signed [DP_W-1:0] Z_RND = DP_W'(2 ** (BRG_SHIFT - 1));
  localparam logic signed [DP_W-1:0] LIM_P = DP_W'(BRG_LIM);
  localparam logic signed [DP_W-1:0] LIM_N = -DP_W'(BRG_LIM);
  localparam logic signed [DP_W-1:0] HZ_P  = DP_W'(HALF_Z);
  localparam logic signed [DP_W-1:0] HZ_N  = -DP_W'(HALF_Z);

  logic [2:0]               state;
  logic signed [POS_W-1:0]  cx, cy;
  logic signed [DP_W-1:0]   u, v, z;
  logic [ITER_W-1:0]        iter;
  logic                     origin;
  logic [60:0]              prod;

  logic signed [DP_W-1:0]   xs, ys, du, dv, at, zr, zb;
  logic [61:0]              rsum;
  logic [23:0]              rfull;

  assign busy = (state != C_IDLE);

  always_comb begin
    xs    = DP_W'(cx) <<< GUARD_BITS;
    ys    = DP_W'(cy) <<< GUARD_BITS;
    du    = v >>> iter;
    dv    = u >>> iter;
    at    = $signed(DP_W'(atan_lut(5'(iter))));
    rsum  = 62'(prod) + RAD_RND;
    rfull = rsum[61:38];
    zr    = z + Z_RND;
    zb    = zr >>> BRG_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            cx    <= x;
            cy    <= y;
            state <= C_INIT;
          end
        end
        C_INIT: begin
          // lower half plane: turn the vector half a turn first
          if (cy < 0) begin
            u <= -ys;
            v <= -xs;
            z <= (cx >= 0) ? HZ_P : HZ_N;
          end else begin
            u <= ys;
            v <= xs;
            z <= '0;
          end
          origin <= (cx == 0) && (cy == 0);
          iter   <= '0;
          state  <= C_ITER;
        end
        C_ITER: begin
          if (v > 0) begin
            u <= u + du;
            v <= v - dv;
            z <= z + at;
          end else begin
            u <= u - du;
            v <= v + dv;
            z <= z - at;
          end
          if (iter == ITER_LAST) begin
            state <= C_GAIN;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        C_GAIN: begin
          prod  <= u[30:0] * INV_GAIN;
          state <= C_ROUND;
        end
        C_ROUND: begin
          if (origin) begin
            radius  <= '0;
            bearing <= '0;
          end else begin
            radius <= (rfull > 24'hFFFFF) ? 20'hFFFFF : rfull[RAD_W-1:0];
            if (zb > LIM_P) begin
              bearing <= BRG_W'(LIM_P);
            end else if (zb < LIM_N) begin
              bearing <= BRG_W'(LIM_N);
            end else begin
              bearing <= BRG_W'(zb);
            end
          end
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == C_IDLE))
    else $error("cordic started while busy");

  a_gain_positive: assert property (@(posedge clk) disable iff (rst)
    (state == C_GAIN) |-> !u[DP_W-1])
    else $error("cordic magnitude went negative");

  a_iter_exit: assert property (@(posedge clk) disable iff (rst)
    (state == C_ITER && iter == ITER_LAST) |=> (state == C_GAIN))
    else $error("cordic missed the end of the rotation sweep");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for cartesian_grid_point_generator_core: drives requests and
// register writes, predicts each grid point (position, radius, bearing) and
// checks it. Needs cgpg_pkg, cgpg_if and the core with its CORDIC unit.
`timescale 1ns / 1ps

module tb_top;
  import cgpg_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int ITEM_TARGET   = 700;

  // atan(2^-i) in degrees, ANG_FRAC fraction bits
  localparam longint ARCTAN [CORDIC_ITERS_DEF] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833
  };

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic        [RAD_W-1:0] radius;
    logic signed [BRG_W-1:0] bearing;
    logic                    last_point;
  } grid_point_t;

  class grid_point_tracker;
    int          steps_x = 1;
    int          steps_y = 1;
    int          spacing = 256;
    bit          incl_zero = 0;
    int          col = 0;
    int          row = 0;
    bit          walking = 0;
    int          mismatches = 0;
    grid_point_t pending_points[$];

    function void set_reg(logic [CFG_A-1:0] idx, int unsigned val);
      case (idx)
        REG_STEPS_X:      steps_x = val & 32'h3f;
        REG_STEPS_Y:      steps_y = val & 32'h3f;
        REG_SPACING:      spacing = val & 32'h1fff;
        REG_INCLUDE_ZERO: incl_zero = val[0];
        default: ;
      endcase
    endfunction

    // rows step inside, columns outside
    function void advance(int sy);
      row++;
      if (row > sy) begin
        row = -sy;
        col++;
      end
    endfunction

    function void to_polar(longint x, longint y, output logic [RAD_W-1:0] rad,
                           output logic signed [BRG_W-1:0] brg);
      longint u, v, z, du, dv, r, b;
      int i;
      rad = '0;
      brg = '0;
      if (x == 0 && y == 0) return;
      u = y * (64'sd1 << GUARD_BITS);
      v = x * (64'sd1 << GUARD_BITS);
      z = 0;
      // fold the lower half-plane over and start the angle at a half turn
      if (u < 0) begin
        u = -u;
        v = -v;
        z = (x >= 0) ? longint'(HALF_Z) : -longint'(HALF_Z);
      end
      for (i = 0; i < CORDIC_ITERS_DEF; i++) begin
        du = v >>> i;
        dv = u >>> i;
        if (v > 0) begin
          u += du;
          v -= dv;
          z += ARCTAN[i];
        end else begin
          u -= du;
          v += dv;
          z -= ARCTAN[i];
        end
      end
      r = (u * longint'(INV_GAIN) + (64'sd1 << 37)) >>> 38;
      if (r > 1048575) r = 1048575;
      b = (z + (64'sd1 << (BRG_SHIFT - 1))) >>> BRG_SHIFT;
      if (b > BRG_LIM) b = BRG_LIM;
      if (b < -BRG_LIM) b = -BRG_LIM;
      rad = r[RAD_W-1:0];
      brg = b[BRG_W-1:0];
    endfunction

    // returns 1 when the request yields a point
    function bit take_request(bit restart);
      int sx, sy;
      longint x, y;
      grid_point_t p;
      sx = (steps_x > MAX_STEPS) ? MAX_STEPS : steps_x;
      sy = (steps_y > MAX_STEPS) ? MAX_STEPS : steps_y;
      if (sx == 0 && sy == 0 && !incl_zero) begin
        walking = 0;
        return 0;
      end
      if (restart || !walking || col < -sx || col > sx || row < -sy || row > sy) begin
        col = -sx;
        row = -sy;
        walking = 1;
      end
      if (col == 0 && row == 0 && !incl_zero) advance(sy);
      x = longint'(col) * spacing;
      y = longint'(row) * spacing;
      p.x_pos = x[POS_W-1:0];
      p.y_pos = y[POS_W-1:0];
      to_polar(x, y, p.radius, p.bearing);
      p.last_point = (col == sx && row == sy);
      if (p.last_point) walking = 0;
      else advance(sy);
      pending_points = {pending_points, p};
      return 1;
    endfunction

    function void field_check(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_point(grid_point_t got);
      grid_point_t want;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point: expected none, actual x=%0d y=%0d", $time,
                 got.x_pos, got.y_pos);
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      field_check("x_pos", want.x_pos, got.x_pos);
      field_check("y_pos", want.y_pos, got.y_pos);
      field_check("radius", want.radius, got.radius);
      field_check("bearing", want.bearing, got.bearing);
      field_check("last_point", want.last_point, got.last_point);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_A-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  bit               calm = 0;
  int               points_asked = 0;
  grid_point_tracker tracker = new();

  cgpg_req_if req_ch ();
  cgpg_pt_if  pt_ch ();

  cartesian_grid_point_generator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .pt        (pt_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // called and returns at a falling edge
  task automatic send_request(input bit restart);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.restart <= restart;
    do @(posedge clk); while (!req_ch.ready);
    points_asked += tracker.take_request(restart);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_points.size() != 0) @(negedge clk);
  endtask

  // drain, then give a request that yields nothing time to leave the core
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, val);
    @(negedge clk);
  endtask

  // receiver
  initial begin
    grid_point_t got;
    int stall;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        pt_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pt_ch.ready <= 1'b1;
      do @(posedge clk); while (!pt_ch.valid);
      got.x_pos      = pt_ch.x_pos;
      got.y_pos      = pt_ch.y_pos;
      got.radius     = pt_ch.radius;
      got.bearing    = pt_ch.bearing;
      got.last_point = pt_ch.last_point;
      tracker.match_point(got);
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("** cartesian_grid_point_generator_core: FAILED **");
    $finish;
  end

  initial begin
    int i, n, kind, hold_at, grid, sx, sy, spc;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.restart = 1'b0;
    pt_ch.ready    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default 3x3 grid without the origin: walk past the end and wrap
    for (i = 0; i < 4; i++) send_request(1'b0);
    drain();
    for (i = 0; i < 5; i++) send_request(1'b0);
    send_request(1'b1);

    // largest grid and spacing: most negative corner
    settle();
    write_reg(REG_STEPS_X, MAX_STEPS);
    write_reg(REG_STEPS_Y, MAX_STEPS);
    write_reg(REG_SPACING, 8191);
    write_reg(REG_INCLUDE_ZERO, 1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // empty grid gives nothing
    settle();
    write_reg(REG_STEPS_X, 0);
    write_reg(REG_STEPS_Y, 0);
    write_reg(REG_INCLUDE_ZERO, 0);
    send_request(1'b0);
    send_request(1'b1);

    // origin only: every point is the last
    settle();
    write_reg(REG_INCLUDE_ZERO, 1);
    send_request(1'b0);
    send_request(1'b0);

    // zero spacing: every point sits at the origin by value
    settle();
    write_reg(REG_STEPS_X, 1);
    write_reg(REG_STEPS_Y, 1);
    write_reg(REG_SPACING, 0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // random phases; the walk carries over unless a register change moves it out of range
    while (points_asked < ITEM_TARGET) begin
      settle();
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin sx = $urandom_range(32, 63); sy = 0; end
        1: begin sx = 0; sy = $urandom_range(32, 63); end
        2: begin sx = 0; sy = 0; end
        default: begin sx = $urandom_range(0, 3); sy = $urandom_range(0, 3); end
      endcase
      case ($urandom_range(0, 7))
        0: spc = 0;
        1: spc = 8191;
        default: spc = $urandom_range(0, 8191);
      endcase
      if (sx != tracker.steps_x || $urandom_range(0, 3) == 0) write_reg(REG_STEPS_X, sx);
      if (sy != tracker.steps_y || $urandom_range(0, 3) == 0) write_reg(REG_STEPS_Y, sy);
      if ($urandom_range(0, 3) != 0) write_reg(REG_SPACING, spc);
      if ($urandom_range(0, 2) == 0) write_reg(REG_INCLUDE_ZERO, $urandom_range(0, 1));
      grid = (2 * tracker.steps_x + 1) * (2 * tracker.steps_y + 1) - (tracker.incl_zero ? 0 : 1);
      n = (grid == 0) ? $urandom_range(1, 3) : grid + $urandom_range(0, 4);
      if (n > 140) n = 140;
      hold_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : 0;
      for (i = 1; i <= n; i++) begin
        if (i == hold_at) drain();
        send_request($urandom_range(0, 19) == 0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.pending_points.size() != 0) begin
      $display("%0t: %0d expected points never arrived", $time,
               tracker.pending_points.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("** cartesian_grid_point_generator_core: PASSED **");
    end else begin
      $display("** cartesian_grid_point_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
